// ----- rtl/core/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and helpers for the Playfair pair cipher block.
// ----------------------------------------------------------------------------
package pfc_pkg;

  // Square geometry and alphabet
  localparam int SQUARE_SIDE = 5;
  localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
  localparam int LETTERS     = 26;
  localparam int LETTER_W    = 5;
  localparam int CMD_W       = 2;
  localparam int COORD_W     = $clog2(SQUARE_SIDE);
  localparam int IDX_W       = $clog2(CELLS);
  localparam int FILL_W      = $clog2(LETTERS + 1);
  localparam int POS_W       = 2 * COORD_W;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [IDX_W-1:0]    cell_idx_t;

  localparam coord_t LAST_COORD = coord_t'(SQUARE_SIDE - 1);

  // Row/column of a letter within the square
  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_KEY     = 2'd1,
    CMD_ENCRYPT = 2'd2,
    CMD_DECRYPT = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_FILL,
    ST_RD_A,
    ST_RD_B,
    ST_CALC,
    ST_RD_O2,
    ST_FIN,
    ST_DONE
  } state_t;

  // One write into both tables: square[index] = letter, position[letter] = pos
  typedef struct packed {
    logic      en;
    letter_t   letter;
    cell_idx_t index;
    pos_t      pos;
  } ram_wr_t;

  // Square build status, seen by the top-level checks
  typedef struct packed {
    logic [IDX_W-1:0]   key_count;
    logic               complete;
    logic [LETTERS-1:0] mask;
  } status_t;

  // One step along a row or column with wrap, forward or back
  function automatic coord_t coord_step(coord_t v, logic back);
    coord_t r;
    if (back) begin
      r = (v == '0) ? LAST_COORD : coord_t'(v - coord_t'(1));
    end else begin
      r = (v == LAST_COORD) ? '0 : coord_t'(v + coord_t'(1));
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/pfc_ram.sv -----
// ----------------------------------------------------------------------------
// pfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/pfc_cell_unit.sv -----
// ----------------------------------------------------------------------------
// pfc_cell_unit
// Shared Playfair rule unit: from one letter's position and its partner's,
// gives the square cell that the letter turns into.
// ----------------------------------------------------------------------------
module pfc_cell_unit (
  input  pfc_pkg::pos_t      own,
  input  pfc_pkg::pos_t      other,
  input  logic               decrypt,
  output pfc_pkg::cell_idx_t target
);
  import pfc_pkg::*;

  coord_t row;
  coord_t col;

  // same row wins (covers equal letters), then same column, else rectangle
  always_comb begin
    if (own.row == other.row) begin
      row = own.row;
      col = coord_step(own.col, decrypt);
    end else if (own.col == other.col) begin
      row = coord_step(own.row, decrypt);
      col = own.col;
    end else begin
      row = own.row;
      col = other.col;
    end
  end

  // row * 5 + col as shift and add
  assign target = cell_idx_t'({row, 2'b00}) + cell_idx_t'(row) + cell_idx_t'(col);

endmodule

// ----- rtl/core/pfc_seq.sv -----
// ----------------------------------------------------------------------------
// pfc_seq
// Command sequencer: builds the square from key letters, completes it one
// letter per cycle, then looks up and transforms one pair through the tables.
// ----------------------------------------------------------------------------
module pfc_seq (
  input  logic               clk,
  input  logic               rst,
  // command word in
  input  logic               in_valid,
  output logic               in_ready,
  input  pfc_pkg::cmd_t      in_cmd,
  input  pfc_pkg::letter_t   in_a,
  input  pfc_pkg::letter_t   in_b,
  // result word out
  output logic               res_valid,
  input  logic               res_ready,
  output pfc_pkg::letter_t   res_first,
  output pfc_pkg::letter_t   res_second,
  output logic               res_nf,
  // table ports
  output pfc_pkg::ram_wr_t   wr,
  output pfc_pkg::letter_t   pos_raddr,
  input  pfc_pkg::pos_t      pos_rdata,
  output pfc_pkg::cell_idx_t sq_raddr,
  input  pfc_pkg::letter_t   sq_rdata,
  // build status
  output pfc_pkg::status_t   status
);
  import pfc_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   key_count;
  coord_t             add_row;
  coord_t             add_col;
  logic [LETTERS-1:0] mask;
  logic               complete;
  logic [FILL_W-1:0]  fill_letter;

  letter_t            a_r;
  letter_t            b_r;
  logic               dec_r;
  pos_t               pos_a;
  pos_t               pos_b;
  letter_t            o1;
  letter_t            o2;
  logic               nf;

  logic               accept;
  logic               add_ok;
  logic               fill_ok;
  logic               fill_used;
  logic               a_hit;
  logic               b_hit;
  pos_t               unit_own;
  pos_t               unit_other;
  cell_idx_t          unit_cell;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // key letter goes in only if new, in range and the square is still open
  assign add_ok = !complete && (a_r < letter_t'(LETTERS)) && !mask[a_r] &&
                  (key_count < IDX_W'(CELLS));

  // completion walks the alphabet one letter a cycle
  assign fill_ok   = (key_count < IDX_W'(CELLS)) && (fill_letter < FILL_W'(LETTERS));
  assign fill_used = fill_ok ? mask[fill_letter[LETTER_W-1:0]] : 1'b1;

  // a letter is in the square exactly when its mask bit is set
  assign a_hit = (a_r < letter_t'(LETTERS)) ? mask[a_r] : 1'b0;
  assign b_hit = (b_r < letter_t'(LETTERS)) ? mask[b_r] : 1'b0;

  // shared rule unit: first letter in CALC, second in RD_O2
  assign unit_own   = (state == ST_CALC) ? pos_a : pos_b;
  assign unit_other = (state == ST_CALC) ? pos_rdata : pos_a;

  pfc_cell_unit u_cell (
    .own     (unit_own),
    .other   (unit_other),
    .decrypt (dec_r),
    .target  (unit_cell)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_CLEAR:                 state_next = ST_IDLE;
            CMD_KEY:                   state_next = ST_ADD;
            CMD_ENCRYPT, CMD_DECRYPT:  state_next = complete ? ST_RD_A : ST_FILL;
            default:                   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD:   state_next = ST_IDLE;
      ST_FILL:  state_next = fill_ok ? ST_FILL : ST_RD_A;
      ST_RD_A:  state_next = (a_hit && b_hit) ? ST_RD_B : ST_DONE;
      ST_RD_B:  state_next = ST_CALC;
      ST_CALC:  state_next = ST_RD_O2;
      ST_RD_O2: state_next = ST_FIN;
      ST_FIN:   state_next = ST_DONE;
      ST_DONE:  state_next = res_ready ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // table access and result handshake
  always_comb begin
    wr.en     = ((state == ST_ADD) && add_ok) ||
                ((state == ST_FILL) && fill_ok && !fill_used);
    wr.letter = (state == ST_ADD) ? a_r : fill_letter[LETTER_W-1:0];
    wr.index  = key_count;
    wr.pos    = '{row: add_row, col: add_col};
    pos_raddr = (state == ST_RD_A) ? a_r : b_r;
    sq_raddr  = unit_cell;
    res_valid = (state == ST_DONE);
  end

  assign res_first  = o1;
  assign res_second = o2;
  assign res_nf     = nf;

  assign status.key_count = key_count;
  assign status.complete  = complete;
  assign status.mask      = mask;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      key_count   <= '0;
      add_row     <= '0;
      add_col     <= '0;
      mask        <= '0;
      complete    <= 1'b0;
      fill_letter <= '0;
    end else begin
      state <= state_next;
      if (accept && (in_cmd == CMD_CLEAR)) begin
        key_count   <= '0;
        add_row     <= '0;
        add_col     <= '0;
        mask        <= '0;
        complete    <= 1'b0;
        fill_letter <= '0;
      end
      // one cell appended
      if (wr.en) begin
        key_count <= key_count + IDX_W'(1);
        mask      <= mask | (LETTERS'(1) << wr.letter);
        if (add_col == LAST_COORD) begin
          add_col <= '0;
          add_row <= add_row + coord_t'(1);
        end else begin
          add_col <= add_col + coord_t'(1);
        end
      end
      if (state == ST_FILL) begin
        if (fill_ok) begin
          fill_letter <= fill_letter + FILL_W'(1);
        end else begin
          complete <= 1'b1;
        end
      end
    end
  end

  // pair datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r   <= in_a;
      b_r   <= in_b;
      dec_r <= (in_cmd == CMD_DECRYPT);
    end
    case (state)
      ST_RD_A: begin
        nf <= !(a_hit && b_hit);
        o1 <= '0;
        o2 <= '0;
      end
      ST_RD_B:  pos_a <= pos_rdata;
      ST_CALC:  pos_b <= pos_rdata;
      ST_RD_O2: o1    <= sq_rdata;
      ST_FIN:   o2    <= sq_rdata;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/playfair_pair_cipher_top.sv -----
// ----------------------------------------------------------------------------
// playfair_pair_cipher_top
// Playfair cipher on letters coded 0..25 with a 5x5 square built from a key.
// ----------------------------------------------------------------------------
// One word in at a time; the block takes no new word until the current one is
// done. An encrypt or decrypt word reads the two tables through their single
// read ports (letter position, then square cell, each read twice in turn); a
// pair with a letter missing from the square skips the later reads and goes
// straight to its result. The first pair after a key also walks the alphabet
// one letter per cycle to complete the square, then marks it complete. The
// result sits in an output register, so a new word is taken while the last
// result still waits. Letters not in the square give not_found with both
// output letters zero.
module playfair_pair_cipher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [4:0] lead_letter, [9:5] partner_letter
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [4:0] out_first, [9:5] out_second
  output logic        m_tuser    // [0] not_found
);
  import pfc_pkg::*;

  ram_wr_t   wr;
  letter_t   pos_raddr;
  logic [POS_W-1:0] pos_rdata;
  cell_idx_t sq_raddr;
  letter_t   sq_rdata;
  status_t   status;

  logic      res_valid;
  logic      res_ready;
  letter_t   res_first;
  letter_t   res_second;
  logic      res_nf;

  letter_t   out_first;
  letter_t   out_second;
  logic      not_found;

  pfc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_cmd     (cmd_t'(s_tuser)),
    .in_a       (s_tdata[4:0]),
    .in_b       (s_tdata[9:5]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_first  (res_first),
    .res_second (res_second),
    .res_nf     (res_nf),
    .wr         (wr),
    .pos_raddr  (pos_raddr),
    .pos_rdata  (pos_rdata),
    .sq_raddr   (sq_raddr),
    .sq_rdata   (sq_rdata),
    .status     (status)
  );

  // square cells, indexed by cell
  pfc_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (CELLS)
  ) u_square (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.index),
    .wdata (wr.letter),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  // letter positions, indexed by letter
  pfc_ram #(
    .WIDTH (POS_W),
    .DEPTH (LETTERS)
  ) u_position (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.letter),
    .wdata (wr.pos),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_first  <= res_first;
      out_second <= res_second;
      not_found  <= res_nf;
    end
  end

  assign m_tdata = {6'd0, out_second, out_first};
  assign m_tuser = not_found;

  // checks
  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    $countones(status.mask) == int'(status.key_count))
    else $error("key count and letter mask disagree");

  a_complete_full: assert property (@(posedge clk) disable iff (rst)
    status.complete |-> (status.key_count == IDX_W'(CELLS)))
    else $error("square marked complete but not full");

  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && not_found) |-> (out_first == '0 && out_second == '0))
    else $error("not_found result carries letters");

  a_letters_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !not_found) |->
      (out_first < letter_t'(LETTERS) && out_second < letter_t'(LETTERS)))
    else $error("result letter out of range");

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Playfair pair cipher. A software copy of the
// square and its build rules predicts every encrypt and decrypt result; the
// results that come out of the block are checked in order, field by field.
// Directed pairs cover the square rules, then random key-and-text sessions
// run with random input gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import pfc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;    // worst case: full square fill plus pair
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_WORDS   = 1500;
  localparam int TOTAL_WORDS    = 1800;

  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    missing;
  } pair_result_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = CMD_CLEAR;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;

  // Software copy of the square
  letter_t       sq_cells [CELLS];
  int            sq_count;
  logic [25:0]   sq_present;
  bit            sq_done;
  int            sq_fill;

  pair_result_t  pairs_due [$];
  int            words_sent;
  int            fail_count;
  int            idle_cycles;
  bit            calm;
  int            hold_request;
  int            hold_left;
  int            stall_left;

  playfair_pair_cipher_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void square_place(input letter_t l);
    if (sq_count < CELLS) begin
      sq_cells[sq_count] = l;
      sq_count++;
      sq_present[l] = 1'b1;
    end
  endfunction

  function automatic bit square_find(input letter_t l, output int row, output int col);
    row = 0;
    col = 0;
    if (l >= LETTERS) return 1'b0;
    for (int k = 0; k < sq_count; k++) begin
      if (sq_cells[k] == l) begin
        row = k / SQUARE_SIDE;
        col = k % SQUARE_SIDE;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic letter_t square_at(input int row, input int col);
    return sq_cells[(row % SQUARE_SIDE) * SQUARE_SIDE + (col % SQUARE_SIDE)];
  endfunction

  // Apply one word to the software square; queue the pair result if any
  function automatic void cipher_apply(input cmd_t cmd, input letter_t a, input letter_t b);
    int r1, c1, r2, c2, step;
    bit ok;
    pair_result_t res;
    case (cmd)
      CMD_CLEAR: begin
        sq_count   = 0;
        sq_present = '0;
        sq_done    = 1'b0;
        sq_fill    = 0;
      end
      CMD_KEY: begin
        if (!sq_done && a < LETTERS && !sq_present[a]) square_place(a);
      end
      default: begin
        // first pair after the key completes the square
        if (!sq_done) begin
          while (sq_count < CELLS && sq_fill < LETTERS) begin
            if (!sq_present[sq_fill]) square_place(letter_t'(sq_fill));
            sq_fill++;
          end
          sq_done = 1'b1;
        end
        ok = square_find(a, r1, c1);
        if (ok) ok = square_find(b, r2, c2);
        res = '0;
        if (!ok) begin
          res.missing = 1'b1;
        end else begin
          step = (cmd == CMD_ENCRYPT) ? 1 : SQUARE_SIDE - 1;
          if (r1 == r2) begin
            res.first  = square_at(r1, c1 + step);
            res.second = square_at(r2, c2 + step);
          end else if (c1 == c2) begin
            res.first  = square_at(r1 + step, c1);
            res.second = square_at(r2 + step, c2);
          end else begin
            res.first  = square_at(r1, c2);
            res.second = square_at(r2, c1);
          end
        end
        pairs_due.insert(pairs_due.size(), res);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- driving
  function automatic letter_t ltr(input byte c);
    return letter_t'(c - 8'd97);
  endfunction

  // mostly real letters, now and then a code above z
  function automatic letter_t any_letter();
    return ($urandom_range(0, 15) == 0) ? letter_t'($urandom_range(26, 31))
                                        : letter_t'($urandom_range(0, 25));
  endfunction

  task automatic send_word(input cmd_t cmd, input letter_t a, input letter_t b);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, b, a};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    cipher_apply(cmd, a, b);
    words_sent++;
  endtask

  // sender stops and waits for every pair result, then for the block to settle
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pair of letters; once the square is known, bias towards rows and columns
  task automatic send_pair(input cmd_t cmd);
    int i, j;
    letter_t a, b;
    if (sq_done && $urandom_range(0, 1) == 0) begin
      i = $urandom_range(0, CELLS - 1);
      if ($urandom_range(0, 1) == 0)
        j = (i / SQUARE_SIDE) * SQUARE_SIDE + $urandom_range(0, SQUARE_SIDE - 1);
      else
        j = (i % SQUARE_SIDE) + SQUARE_SIDE * $urandom_range(0, SQUARE_SIDE - 1);
      a = sq_cells[i];
      b = sq_cells[j];
    end else begin
      a = any_letter();
      b = any_letter();
    end
    send_word(cmd, a, b);
  endtask

  function automatic cmd_t pair_cmd();
    return ($urandom_range(0, 1) == 0) ? CMD_ENCRYPT : CMD_DECRYPT;
  endfunction

  // ---------------------------------------------------------------- tests
  // Empty key: square is a..y, z left out
  task automatic test_empty_key();
    send_word(CMD_CLEAR, 5'd31, 5'd31);
    send_word(CMD_ENCRYPT, ltr("a"), ltr("b"));   // same row
    send_word(CMD_ENCRYPT, ltr("d"), ltr("e"));   // row wrap
    send_word(CMD_ENCRYPT, ltr("a"), ltr("f"));   // same column
    send_word(CMD_ENCRYPT, ltr("u"), ltr("a"));   // column wrap
    send_word(CMD_ENCRYPT, ltr("a"), ltr("g"));   // rectangle
    send_word(CMD_ENCRYPT, ltr("c"), ltr("c"));   // equal letters
    send_word(CMD_ENCRYPT, ltr("z"), ltr("a"));   // left-out letter
    send_word(CMD_ENCRYPT, ltr("a"), 5'd31);      // code above z
    send_word(CMD_DECRYPT, ltr("a"), ltr("b"));
    send_word(CMD_DECRYPT, ltr("a"), ltr("u"));
    send_word(CMD_DECRYPT, ltr("e"), ltr("y"));
  endtask

  // Key rules: repeats, bad codes, key after completion
  task automatic test_key_rules();
    send_word(CMD_CLEAR, 5'd0, 5'd0);
    send_word(CMD_KEY, ltr("p"), 5'd31);
    send_word(CMD_KEY, ltr("l"), 5'd0);
    send_word(CMD_KEY, ltr("a"), 5'd0);
    send_word(CMD_KEY, ltr("y"), 5'd0);
    send_word(CMD_KEY, ltr("a"), 5'd0);           // repeat, dropped
    send_word(CMD_KEY, 5'd31, 5'd0);              // out of range, dropped
    send_word(CMD_KEY, ltr("z"), 5'd0);
    send_word(CMD_ENCRYPT, ltr("p"), ltr("z"));
    send_word(CMD_KEY, ltr("x"), 5'd0);           // square complete, dropped
    send_word(CMD_ENCRYPT, ltr("x"), ltr("a"));   // x is the left-out letter
    send_word(CMD_DECRYPT, ltr("l"), ltr("z"));
    send_word(CMD_DECRYPT, ltr("a"), ltr("w"));
  endtask

  // Random sessions: clear, key, a run of pairs, with some noise
  task automatic test_random_sessions(input int target);
    int n, mode;
    letter_t perm [LETTERS];
    letter_t t;
    while (words_sent < target) begin
      if ($urandom_range(0, 9) != 0)
        send_word(CMD_CLEAR, letter_t'($urandom_range(0, 31)), letter_t'($urandom_range(0, 31)));
      mode = $urandom_range(0, 7);
      if (mode == 0) begin
        n = 0;
      end else if (mode == 1) begin
        // full permutation: only the first 25 fit
        for (int k = 0; k < LETTERS; k++) perm[k] = letter_t'(k);
        for (int k = LETTERS - 1; k > 0; k--) begin
          n = $urandom_range(0, k);
          t = perm[k];
          perm[k] = perm[n];
          perm[n] = t;
        end
        for (int k = 0; k < LETTERS; k++)
          send_word(CMD_KEY, perm[k], letter_t'($urandom_range(0, 31)));
        n = 0;
      end else begin
        n = $urandom_range(1, 12);
      end
      repeat (n) send_word(CMD_KEY, any_letter(), letter_t'($urandom_range(0, 31)));
      repeat ($urandom_range(8, 30)) begin
        case ($urandom_range(0, 39))
          0:       send_word(CMD_CLEAR, any_letter(), any_letter());
          1, 2:    send_word(CMD_KEY, any_letter(), any_letter());
          default: send_pair(pair_cmd());
        endcase
      end
    end
  endtask

  // Receiver holds off for a long stretch while pairs keep coming
  task automatic test_output_hold();
    wait_drained();
    hold_request = LONG_HOLD;
    repeat (30) send_pair(pair_cmd());
  endtask

  // Sender waits for every result, then sends a run of pairs
  task automatic test_sender_pause();
    wait_drained();
    repeat (30) send_pair(pair_cmd());
  endtask

  // Final stretch without idling on either side
  task automatic test_steady_tail();
    wait_drained();
    calm = 1'b1;
    test_random_sessions(TOTAL_WORDS);
  endtask

  // ---------------------------------------------------------------- receiver
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    pair_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pairs_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word: first=%0d second=%0d not_found=%0b",
                   m_tdata[4:0], m_tdata[9:5], m_tuser);
      end else begin
        want = pairs_due.pop_front();
        if (m_tdata[4:0] !== want.first || m_tdata[9:5] !== want.second ||
            m_tuser !== want.missing) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected first=%0d second=%0d not_found=%0b, got %0d %0d %0b",
                     want.first, want.second, want.missing,
                     m_tdata[4:0], m_tdata[9:5], m_tuser);
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    sq_count     = 0;
    sq_present   = '0;
    sq_done      = 1'b0;
    sq_fill      = 0;
    words_sent   = 0;
    fail_count   = 0;
    calm         = 1'b0;
    hold_request = 0;
    hold_left    = 0;
    stall_left   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_key();
    test_key_rules();
    test_random_sessions(RANDOM_WORDS);
    test_output_hold();
    test_sender_pause();
    test_steady_tail();
    wait_drained();

    if (fail_count == 0 && pairs_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
